### src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, codes, payload types and controller/datapath types.
// ----------------------------------------------------------------------------
package ffha_pkg;

   // Default sizes of the arena and the block table.
   localparam int ARENA_BYTES_DEF  = 1048576;
   localparam int HEADER_BYTES_DEF = 32;
   localparam int MAX_BLOCKS_DEF   = 64;

   // Field widths fixed by the request and response formats.
   localparam int REQ_BYTES_W = 21;
   localparam int ADDR_W      = 20;
   localparam int STATUS_W    = 2;

   // Payload sizes are rounded up to this granule.
   localparam int GRANULE_BYTES = 16;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FREE_AGAIN = 2'd3;

   // Operation codes.
   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   typedef struct packed {
      logic                   operation;
      logic [REQ_BYTES_W-1:0] request_bytes;
      logic [ADDR_W-1:0]      release_address;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   granted_address;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SPLIT_TAIL,
      S_SPLIT_HEAD,
      S_MERGE_RD,
      S_MERGE_EV,
      S_MERGE_FLUSH,
      S_FINISH
   } ctrl_state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_INIT,
      CMD_ACCEPT,
      CMD_SCAN_NEXT,
      CMD_ALLOC_TAKE,
      CMD_SHIFT_START,
      CMD_SHIFT_WR,
      CMD_SPLIT_TAIL,
      CMD_SPLIT_HEAD,
      CMD_FREE_AGAIN,
      CMD_FREE_MARK,
      CMD_MERGE_STEP,
      CMD_MERGE_FLUSH,
      CMD_LOAD_RSP
   } dp_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic hit;
      logic entry_used;
      logic split_ok;
      logic shift_end;
      logic is_release;
      logic req_bad;
      logic rsp_free;
   } dp_status_type;

endpackage

### src/ffha_chan_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface ffha_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Address-ordered block table with first-fit search, splitting and merging.
// ----------------------------------------------------------------------------
// The allocator handles one request at a time over a block table memory with
// one write port and one registered read port; each table entry visited is
// addressed through the scan pointer and then evaluated from the registered
// data. An allocate request scans up to the granted block and, when the block
// is split, shifts the later entries up one by one; a miss scans the whole
// table. A release scans to find its block and, when the block was in use,
// makes a full merge pass over the table. After reset the block writes the
// initial free block before it accepts its first request. The response is
// held in an output register, so a new request is accepted while the previous
// response still waits to be taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ffha_chan_if.sink   req,
   ffha_chan_if.source rsp
);

   // Command and status buses between the sequencer and the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller alone decides when a request is taken.
   ffha_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .status    (status),
      .req_ready (req.ready),
      .cmd       (cmd)
   );

   // The datapath owns the block table and the response register.
   ffha_datapath #(
      .ARENA_BYTES  (ARENA_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req.payload),
      .rsp_ready   (rsp.ready),
      .rsp_valid   (rsp.valid),
      .rsp_payload (rsp.payload),
      .status      (status)
   );

endmodule

### src/ffha_datapath.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Block table memory, scan pointers, working entry and response register.
// ----------------------------------------------------------------------------
module ffha_datapath import ffha_pkg::*; #(
   parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      cmd,
   input  req_payload_type req_payload,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   output dp_status_type   status
);

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int XW = ((AW > REQ_BYTES_W) ? AW : REQ_BYTES_W) + 2;
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [XW-1:0] HDR_X    = XW'(HEADER_BYTES);
   localparam logic [XW-1:0] ARENA_X  = XW'(ARENA_BYTES);
   localparam logic [XW-1:0] GRAN_X   = XW'(GRANULE_BYTES);
   localparam logic [XW-1:0] GMASK_X  = ~(XW'(GRANULE_BYTES - 1));
   localparam logic [CW-1:0] MAX_C    = CW'(MAX_BLOCKS);

   typedef struct packed {
      logic [AW-1:0] start;
      logic [AW-1:0] size;
      logic          used;
   } entry_type;

   entry_type mem [MAX_BLOCKS];
   entry_type rd_data_ff;

   logic                mem_we;
   logic [IW-1:0]       mem_wa;
   entry_type           mem_wd;

   logic                op_ff, op_in;
   logic [XW-1:0]       need_ff, need_in;
   logic [AW-1:0]       target_ff, target_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       hit_ff, hit_in;
   logic [CW-1:0]       wr_ptr_ff, wr_ptr_in;
   entry_type           cur_ff, cur_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic [XW-1:0] req_n;
   logic [XW-1:0] req_need;
   logic [XW-1:0] rel_x;
   logic [XW-1:0] rel_base;
   logic          rel_bad;
   logic [XW-1:0] rd_size_x;
   logic [XW-1:0] cur_end_x;
   logic          can_merge;

   always_comb begin
      req_n    = XW'(req_payload.request_bytes);
      if (req_n == '0) begin
         req_n = XW'(1);
      end
      req_need = (req_n + GRAN_X - XW'(1)) & GMASK_X;
      rel_x    = XW'(req_payload.release_address);
      rel_base = rel_x - HDR_X;
      rel_bad  = (rel_x == '0) || (rel_x < HDR_X) || (rel_base >= ARENA_X);
      rd_size_x = XW'(rd_data_ff.size);
      cur_end_x = XW'(cur_ff.start) + HDR_X + XW'(cur_ff.size);
      can_merge = !cur_ff.used && !rd_data_ff.used && (cur_end_x == XW'(rd_data_ff.start));
   end

   always_comb begin
      status.scan_end   = (ptr_ff == count_ff);
      status.hit        = (op_ff == OP_RELEASE) ? (rd_data_ff.start == target_ff)
                                                : (!rd_data_ff.used && rd_size_x >= need_ff);
      status.entry_used = rd_data_ff.used;
      status.split_ok   = (rd_size_x >= need_ff + HDR_X + GRAN_X) && (count_ff < MAX_C);
      status.shift_end  = (ptr_ff == hit_ff);
      status.is_release = op_ff;
      status.req_bad    = (req_payload.operation == OP_RELEASE) && rel_bad;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      op_in         = op_ff;
      need_in       = need_ff;
      target_in     = target_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      hit_in        = hit_ff;
      wr_ptr_in     = wr_ptr_ff;
      cur_in        = cur_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      case (cmd)
         CMD_INIT: begin
            mem_we         = 1'b1;
            mem_wd.start   = '0;
            mem_wd.size    = AW'(ARENA_BYTES - HEADER_BYTES);
            mem_wd.used    = 1'b0;
            count_in       = CW'(1);
         end
         CMD_ACCEPT: begin
            op_in         = req_payload.operation;
            need_in       = req_need;
            target_in     = rel_base[AW-1:0];
            ptr_in        = '0;
            res_addr_in   = '0;
            res_status_in = (req_payload.operation == OP_RELEASE) ? STATUS_IGNORED
                                                                   : STATUS_NO_FIT;
         end
         CMD_SCAN_NEXT: begin
            ptr_in = ptr_ff + CW'(1);
         end
         CMD_ALLOC_TAKE: begin
            mem_we        = 1'b1;
            mem_wa        = ptr_ff[IW-1:0];
            mem_wd        = rd_data_ff;
            mem_wd.used   = 1'b1;
            res_addr_in   = ADDR_W'(XW'(rd_data_ff.start) + HDR_X);
            res_status_in = STATUS_DONE;
         end
         CMD_SHIFT_START: begin
            cur_in = rd_data_ff;
            hit_in = ptr_ff;
            ptr_in = count_ff - CW'(1);
         end
         CMD_SHIFT_WR: begin
            mem_we = 1'b1;
            mem_wa = IW'(ptr_ff + CW'(1));
            mem_wd = rd_data_ff;
            ptr_in = ptr_ff - CW'(1);
         end
         CMD_SPLIT_TAIL: begin
            mem_we       = 1'b1;
            mem_wa       = IW'(hit_ff + CW'(1));
            mem_wd.start = AW'(XW'(cur_ff.start) + HDR_X + need_ff);
            mem_wd.size  = AW'(XW'(cur_ff.size) - need_ff - HDR_X);
            mem_wd.used  = 1'b0;
            count_in     = count_ff + CW'(1);
         end
         CMD_SPLIT_HEAD: begin
            mem_we        = 1'b1;
            mem_wa        = hit_ff[IW-1:0];
            mem_wd.start  = cur_ff.start;
            mem_wd.size   = AW'(need_ff);
            mem_wd.used   = 1'b1;
            res_addr_in   = ADDR_W'(XW'(cur_ff.start) + HDR_X);
            res_status_in = STATUS_DONE;
         end
         CMD_FREE_AGAIN: begin
            res_status_in = STATUS_FREE_AGAIN;
         end
         CMD_FREE_MARK: begin
            mem_we      = 1'b1;
            mem_wa      = ptr_ff[IW-1:0];
            mem_wd      = rd_data_ff;
            mem_wd.used = 1'b0;
            ptr_in      = '0;
            wr_ptr_in   = '0;
         end
         CMD_MERGE_STEP: begin
            if (ptr_ff == '0) begin
               cur_in = rd_data_ff;
            end else if (can_merge) begin
               cur_in.size = AW'(XW'(cur_ff.size) + HDR_X + rd_size_x);
            end else begin
               mem_we    = 1'b1;
               mem_wa    = wr_ptr_ff[IW-1:0];
               mem_wd    = cur_ff;
               wr_ptr_in = wr_ptr_ff + CW'(1);
               cur_in    = rd_data_ff;
            end
            ptr_in = ptr_ff + CW'(1);
         end
         CMD_MERGE_FLUSH: begin
            mem_we        = 1'b1;
            mem_wa        = wr_ptr_ff[IW-1:0];
            mem_wd        = cur_ff;
            count_in      = wr_ptr_ff + CW'(1);
            res_addr_in   = '0;
            res_status_in = STATUS_DONE;
         end
         CMD_LOAD_RSP: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.granted_address = res_addr_ff;
            rsp_data_in.status          = res_status_ff;
         end
         default: begin
         end
      endcase
   end

   // Single write port, one registered read port at the scan pointer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[ptr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      need_ff       <= need_in;
      target_ff     <= target_in;
      ptr_ff        <= ptr_in;
      hit_ff        <= hit_in;
      wr_ptr_ff     <= wr_ptr_in;
      cur_ff        <= cur_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

### src/ffha_controller.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences table scan, split insertion and merge pass over the datapath.
// ----------------------------------------------------------------------------
module ffha_controller import ffha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output logic          req_ready,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = status.req_bad ? S_FINISH : S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = status.scan_end ? S_FINISH : S_SCAN_EV;
         end
         S_SCAN_EV: begin
            if (!status.hit) begin
               state_in = S_SCAN_RD;
            end else if (status.is_release) begin
               state_in = status.entry_used ? S_MERGE_RD : S_FINISH;
            end else begin
               state_in = status.split_ok ? S_SHIFT_RD : S_FINISH;
            end
         end
         S_SHIFT_RD: begin
            state_in = status.shift_end ? S_SPLIT_TAIL : S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            state_in = S_SHIFT_RD;
         end
         S_SPLIT_TAIL: begin
            state_in = S_SPLIT_HEAD;
         end
         S_SPLIT_HEAD: begin
            state_in = S_FINISH;
         end
         S_MERGE_RD: begin
            state_in = status.scan_end ? S_MERGE_FLUSH : S_MERGE_EV;
         end
         S_MERGE_EV: begin
            state_in = S_MERGE_RD;
         end
         S_MERGE_FLUSH: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd = CMD_INIT;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd = CMD_ACCEPT;
            end
         end
         S_SCAN_EV: begin
            if (!status.hit) begin
               cmd = CMD_SCAN_NEXT;
            end else if (status.is_release) begin
               cmd = status.entry_used ? CMD_FREE_MARK : CMD_FREE_AGAIN;
            end else begin
               cmd = status.split_ok ? CMD_SHIFT_START : CMD_ALLOC_TAKE;
            end
         end
         S_SHIFT_WR: begin
            cmd = CMD_SHIFT_WR;
         end
         S_SPLIT_TAIL: begin
            cmd = CMD_SPLIT_TAIL;
         end
         S_SPLIT_HEAD: begin
            cmd = CMD_SPLIT_HEAD;
         end
         S_MERGE_EV: begin
            cmd = CMD_MERGE_STEP;
         end
         S_MERGE_FLUSH: begin
            cmd = CMD_MERGE_FLUSH;
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd = CMD_LOAD_RSP;
            end
         end
         default: begin
            cmd = CMD_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sim/ffha_checker.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator checker
// Watches the request and response channels, keeps its own copy of the block
// table, predicts every response and compares it with the actual response.
// ----------------------------------------------------------------------------
module ffha_checker import ffha_pkg::*; #(
   parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              error_count,
   output int              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [ADDR_W-1:0] heap_start [MAX_BLOCKS];
   logic [ADDR_W-1:0] heap_size  [MAX_BLOCKS];
   logic              heap_used  [MAX_BLOCKS];
   int                heap_count;
   rsp_payload_type   expected_rsp_q [$];

   assign pending_count = expected_rsp_q.size();

   task automatic heap_clear();
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         heap_start[k] = '0;
         heap_size[k]  = '0;
         heap_used[k]  = 1'b0;
      end
      heap_size[0] = ADDR_W'(ARENA_BYTES - HEADER_BYTES);
      heap_count = 1;
   endtask

   function automatic void heap_remove(input int idx);
      for (int k = idx; k + 1 < heap_count; k++) begin
         heap_start[k] = heap_start[k+1];
         heap_size[k]  = heap_size[k+1];
         heap_used[k]  = heap_used[k+1];
      end
      heap_count--;
   endfunction

   function automatic void heap_merge();
      int       i;
      longint   tail;
      i = 0;
      while (i + 1 < heap_count) begin
         tail = longint'(heap_start[i]) + HEADER_BYTES + heap_size[i];
         if (!heap_used[i] && !heap_used[i+1] && tail == longint'(heap_start[i+1])) begin
            heap_size[i] = heap_size[i] + ADDR_W'(HEADER_BYTES) + heap_size[i+1];
            heap_remove(i + 1);
         end else begin
            i++;
         end
      end
   endfunction

   // Applies one request to the table and returns the response it earns.
   function automatic rsp_payload_type heap_apply(input req_payload_type r);
      rsp_payload_type res;
      longint          want;
      longint          sz;
      longint          hdr;
      res.granted_address = '0;
      if (r.operation == OP_ALLOCATE) begin
         want = r.request_bytes;
         if (want == 0) want = 1;
         want = (want + 15) & ~longint'(15);
         res.status = STATUS_NO_FIT;
         for (int i = 0; i < heap_count; i++) begin
            sz = heap_size[i];
            if (heap_used[i] || sz < want) continue;
            if (sz >= want + HEADER_BYTES + GRANULE_BYTES && heap_count < MAX_BLOCKS) begin
               for (int k = heap_count; k > i + 1; k--) begin
                  heap_start[k] = heap_start[k-1];
                  heap_size[k]  = heap_size[k-1];
                  heap_used[k]  = heap_used[k-1];
               end
               heap_count++;
               heap_start[i+1] = ADDR_W'(heap_start[i] + HEADER_BYTES + want);
               heap_size[i+1]  = ADDR_W'(sz - want - HEADER_BYTES);
               heap_used[i+1]  = 1'b0;
               heap_size[i]    = ADDR_W'(want);
            end
            heap_used[i] = 1'b1;
            res.granted_address = ADDR_W'(heap_start[i] + HEADER_BYTES);
            res.status = STATUS_DONE;
            break;
         end
      end else begin
         res.status = STATUS_IGNORED;
         hdr = longint'(r.release_address) - HEADER_BYTES;
         if (r.release_address != 0 && hdr >= 0 && hdr < ARENA_BYTES) begin
            for (int i = 0; i < heap_count; i++) begin
               if (longint'(heap_start[i]) != hdr) continue;
               if (!heap_used[i]) begin
                  res.status = STATUS_FREE_AGAIN;
               end else begin
                  heap_used[i] = 1'b0;
                  heap_merge();
                  res.status = STATUS_DONE;
               end
               break;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want_rsp;
      if (reset) begin
         heap_clear();
         expected_rsp_q.delete();
         error_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response addr=%h status=%0d", $time,
                        rsp_payload.granted_address, rsp_payload.status);
               error_count <= error_count + 1;
            end else begin
               want_rsp = expected_rsp_q.pop_front();
               if (want_rsp !== rsp_payload) begin
                  $display("%0t: mismatch expected addr=%h status=%0d actual addr=%h status=%0d",
                           $time, want_rsp.granted_address, want_rsp.status,
                           rsp_payload.granted_address, rsp_payload.status);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(heap_apply(req_payload));
      end
   end
endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives directed and random allocate/release requests with random stalls on
// both channels; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import ffha_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ARENA = ARENA_BYTES_DEF;
   localparam int HDR   = HEADER_BYTES_DEF;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   cycle_count;
   bit   quiet_phase;   // No idling on either side near the end of the run.
   bit   hold_rsp;      // Long receiver hold-off requested by the stimulus.

   // Payload offsets handed out so far; releases mostly pick from here.
   logic [ADDR_W-1:0] granted_list [$];

   ffha_chan_if #(req_payload_type) req_ch ();
   ffha_chan_if #(rsp_payload_type) rsp_ch ();

   first_fit_heap_allocator uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   ffha_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_payload   (req_ch.payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_payload   (rsp_ch.payload),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Collect granted offsets so that later releases mostly hit real blocks.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.payload.status == STATUS_DONE
          && rsp_ch.payload.granted_address != 0)
         granted_list.push_back(rsp_ch.payload.granted_address);
   end

   // Watchdog: ends the run as a failure if the block hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("** first_fit_heap_allocator: FAILED **");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready = 1'b0;
            repeat (600) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic send_request(input logic op, input logic [REQ_BYTES_W-1:0] nbytes,
                               input logic [ADDR_W-1:0] addr);
      int gap;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_ch.valid = 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.payload.operation       = op;
      req_ch.payload.request_bytes   = nbytes;
      req_ch.payload.release_address = addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Picks a size: mostly small, sometimes large, rarely the extremes.
   function automatic logic [REQ_BYTES_W-1:0] pick_size();
      case ($urandom_range(0, 19))
         0:       return REQ_BYTES_W'($urandom_range(0, 1048576));
         1:       return REQ_BYTES_W'($urandom_range(0, 2097151));
         2, 3:    return REQ_BYTES_W'($urandom_range(0, 65536));
         default: return REQ_BYTES_W'($urandom_range(0, 4096));
      endcase
   endfunction

   // Picks a release address: mostly a live grant, else noise.
   function automatic logic [ADDR_W-1:0] pick_release();
      int idx;
      if (granted_list.size() > 0 && $urandom_range(0, 9) < 7) begin
         idx = $urandom_range(0, granted_list.size() - 1);
         pick_release = granted_list[idx];
         // Usually forget it, so that repeated frees stay occasional.
         if ($urandom_range(0, 4) != 0) granted_list.delete(idx);
      end else begin
         pick_release = ADDR_W'($urandom);
      end
   endfunction

   initial begin
      logic [ADDR_W-1:0] first_addr;
      quiet_phase = 1'b0;
      hold_rsp = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed part: zero size, granule edges, full arena, oversize,
      // the release special cases and a double free.
      send_request(OP_ALLOCATE, '0, '1);
      send_request(OP_ALLOCATE, 21'd16, '0);
      send_request(OP_ALLOCATE, 21'd17, '0);
      send_request(OP_ALLOCATE, 21'(ARENA), '0);
      send_request(OP_ALLOCATE, '1, '0);
      send_request(OP_RELEASE, '1, '0);                 // null
      send_request(OP_RELEASE, '0, 20'(HDR - 1));       // below the arena
      send_request(OP_RELEASE, '0, '1);                 // no block here
      send_request(OP_RELEASE, '0, 20'(HDR + 8));       // inside a block
      send_request(OP_RELEASE, '0, 20'(HDR));           // first grant
      send_request(OP_RELEASE, '0, 20'(HDR));           // double free
      send_request(OP_ALLOCATE, 21'(ARENA - HDR), '0);  // no fit, the second grant is still live
      send_request(OP_ALLOCATE, 21'd1, '0);             // reuses the freed first block
      send_request(OP_RELEASE, '0, 20'(HDR));
      wait (pending_count == 0);
      granted_list.delete();

      // Fill the table so that the full-table rule is reached.
      for (int i = 0; i < 70; i++) send_request(OP_ALLOCATE, 21'($urandom_range(1, 64)), '0);
      send_request(OP_ALLOCATE, 21'd1000, '0);

      // Long receiver hold-off while requests keep coming.
      hold_rsp = 1'b1;
      for (int i = 0; i < 10; i++) send_request(OP_RELEASE, '0, pick_release());

      // Sender pause until every expected response has arrived.
      wait (pending_count == 0 && !hold_rsp);

      for (int i = 0; i < 800; i++) begin
         if (i == 700) quiet_phase = 1'b1;
         if ($urandom_range(0, 1) == 0)
            send_request(OP_ALLOCATE, pick_size(), ADDR_W'($urandom));
         else
            send_request(OP_RELEASE, REQ_BYTES_W'($urandom), pick_release());
      end

      // Release whatever remains so that merging back to one block is exercised.
      while (granted_list.size() > 0) begin
         first_addr = granted_list.pop_front();
         send_request(OP_RELEASE, '0, first_addr);
         wait (pending_count == 0);
      end

      wait (pending_count == 0);
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("** first_fit_heap_allocator: PASSED **");
      end else begin
         $display("** first_fit_heap_allocator: FAILED **");
      end
      $finish;
   end
endmodule

### filelist.f
src/ffha_pkg.sv
src/ffha_chan_if.sv
src/ffha_datapath.sv
src/ffha_controller.sv
src/first_fit_heap_allocator.sv
sim/ffha_checker.sv
sim/testbench.sv
